@@ rtl/bgauge_pkg.sv @@
// shared widths, constants, register codes and state type for the battery energy gauge
`timescale 1ns / 1ps

package bgauge_pkg;

  localparam int ENERGY_W  = 62;
  localparam int ELAPSED_W = 32;
  localparam int POWER_W   = 24;
  localparam int CUR_W     = 16;
  localparam int VOLT_W    = 16;
  localparam int PROD_W    = POWER_W + ELAPSED_W;
  localparam int NUM_W     = ENERGY_W + 7;
  localparam int PCT_W     = 7;

  localparam int MUL_CNT_W = 5;
  localparam int DIV_CNT_W = 3;
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = 5'd31;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'd7;
  localparam logic [DIV_CNT_W-1:0] DIV_SCALE = 3'd0;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_OC_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UV_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_POWER = 2'd2;

  localparam logic [CUR_W-1:0]   OC_LIMIT_RST    = 16'h7fff;
  localparam logic [VOLT_W-1:0]  UV_LIMIT_RST    = 16'h0000;
  localparam logic [POWER_W-1:0] SLEEP_POWER_RST = 24'h000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_PEAK,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

@@ rtl/bgauge_mult.sv @@
// bit-serial shift-add multiplier: power magnitude times elapsed time, one bit per cycle
`timescale 1ns / 1ps

module bgauge_mult import bgauge_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [POWER_W-1:0]   mcand,
  input  logic [ELAPSED_W-1:0] mplr,
  output logic                 done,
  output logic [PROD_W-1:0]    prod
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [POWER_W-1:0]   mcand_q;
  logic [POWER_W:0]     part;

  // upper half accumulates, lower half shifts the multiplier bits out
  assign part = {1'b0, prod[PROD_W-1:ELAPSED_W]} + (prod[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_q <= mcand;
      prod    <= {{POWER_W{1'b0}}, mplr};
    end else if (busy) begin
      prod <= {part, prod[ELAPSED_W-1:1]};
    end
  end

endmodule

@@ rtl/bgauge_div.sv @@
// restoring divider for floor(energy*100/peak), one quotient bit per cycle
`timescale 1ns / 1ps

module bgauge_div import bgauge_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ENERGY_W-1:0] energy,
  input  logic [ENERGY_W-1:0] peak,
  output logic                done,
  output logic [PCT_W-1:0]    quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     rem;
  logic [NUM_W-2:0]     dsh;
  logic [NUM_W:0]       diff;

  // energy < peak here, so the quotient fits seven bits
  assign diff = {1'b0, rem} - {2'b00, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // 100e = 64e + 32e + 4e, the last term added on the first step
      rem  <= {1'b0, energy, 6'b0} + {2'b0, energy, 5'b0};
      dsh  <= {peak, 6'b0};
      quot <= '0;
    end else if (busy) begin
      if (cnt == DIV_SCALE) begin
        rem <= rem + {5'b0, energy, 2'b0};
      end else begin
        if (!diff[NUM_W]) begin
          rem  <= diff[NUM_W-1:0];
          quot <= {quot[PCT_W-2:0], 1'b1};
        end else begin
          quot <= {quot[PCT_W-2:0], 1'b0};
        end
        dsh <= {1'b0, dsh[NUM_W-2:1]};
      end
    end
  end

endmodule

@@ rtl/battery_energy_gauge.sv @@
// Battery energy gauge top level: handshakes, settings, energy store and sequencing.
// Each request is a sample (kind 0) or a deep-sleep wake-up (kind 1) and gives one result:
// the limit flags, the stored energy in mW*ms (clamped at zero, saturating at the top),
// the peak energy and floor(energy*100/peak). A request is taken only in the idle state;
// the next one waits until the result has been loaded into the output register.
// The sequence runs the 32 steps of the bit-serial power-times-time multiplier, then the
// 8 steps of the percent divider; when the peak is zero or the energy reaches the peak
// the divider is skipped and the percent is 0 or 100. A finished result waits in the
// output register while the next request is taken.
`timescale 1ns / 1ps

module battery_energy_gauge import bgauge_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [ELAPSED_W-1:0]  elapsed_ms,
  input  logic [POWER_W-1:0]    power_mw,
  input  logic [CUR_W-1:0]      current_ma,
  input  logic [VOLT_W-1:0]     voltage_mv,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  overcurrent_flag,
  output logic                  undervoltage_flag,
  output logic [ENERGY_W-1:0]   energy_level,
  output logic [ENERGY_W-1:0]   peak_energy,
  output logic [PCT_W-1:0]      level_percent,
  // settings write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [CUR_W-1:0]   oc_limit;
  logic [VOLT_W-1:0]  uv_limit;
  logic [POWER_W-1:0] sleep_power;

  logic [ENERGY_W-1:0] energy, energy_next;
  logic [ENERGY_W-1:0] peak, peak_next;
  logic [PCT_W-1:0]    pct;
  logic                kind_q, sign_q, neg_q, oc_q, uv_q;

  logic                mul_start, mul_done, div_start, div_done, load_out;
  logic [POWER_W-1:0]  pwr_src, pwr_mag;
  logic [PROD_W-1:0]   prod;
  logic [PCT_W-1:0]    quot;
  logic                neg, pct_zero, pct_full;
  logic [ENERGY_W:0]   sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      oc_limit    <= OC_LIMIT_RST;
      uv_limit    <= UV_LIMIT_RST;
      sleep_power <= SLEEP_POWER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OC_LIMIT:    oc_limit    <= cfg_data[CUR_W-1:0];
        CFG_UV_LIMIT:    uv_limit    <= cfg_data[VOLT_W-1:0];
        CFG_SLEEP_POWER: sleep_power <= cfg_data[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // magnitude of the power that applies to this request
  assign pwr_src = kind ? sleep_power : power_mw;
  assign pwr_mag = pwr_src[POWER_W-1] ? (~pwr_src + 1'b1) : pwr_src;

  bgauge_mult u_mult (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .mcand (pwr_mag),
    .mplr  (elapsed_ms),
    .done  (mul_done),
    .prod  (prod)
  );

  bgauge_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .energy (energy),
    .peak   (peak),
    .done   (div_done),
    .quot   (quot)
  );

  // a zero product counts as a gain
  assign neg = sign_q && (prod != '0);
  assign sum = {1'b0, energy} + {{(ENERGY_W + 1 - PROD_W){1'b0}}, prod};

  always_comb begin
    energy_next = energy;
    if (neg_q) begin
      if ({{(ENERGY_W - PROD_W){1'b0}}, prod} >= energy) begin
        energy_next = '0;
      end else begin
        energy_next = energy - {{(ENERGY_W - PROD_W){1'b0}}, prod};
      end
    end else if (sum[ENERGY_W]) begin
      energy_next = ENERGY_MAX;
    end else begin
      energy_next = sum[ENERGY_W-1:0];
    end
  end

  always_comb begin
    peak_next = peak;
    if (!kind_q && !neg_q && (energy > peak)) begin
      peak_next = energy;
    end
  end

  assign pct_zero = (peak == '0);
  assign pct_full = (energy >= peak);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  if (mul_done) state_next = ST_ACC;
      ST_ACC:  state_next = ST_PEAK;
      ST_PEAK: state_next = ST_CHK;
      ST_CHK:  state_next = (pct_zero || pct_full) ? ST_FIN : ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_FIN;
      ST_FIN:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    mul_start = (state == ST_IDLE) && in_valid;
    div_start = (state == ST_CHK) && !pct_zero && !pct_full;
    load_out  = (state == ST_FIN) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      energy    <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ACC) begin
        energy <= energy_next;
      end
      if (state == ST_PEAK) begin
        peak <= peak_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      kind_q <= kind;
      sign_q <= pwr_src[POWER_W-1];
      oc_q   <= !kind && ($signed(current_ma) > $signed(oc_limit));
      uv_q   <= !kind && (voltage_mv < uv_limit);
    end
    if (state == ST_MUL) begin
      neg_q <= neg;
    end
    if (state == ST_CHK) begin
      pct <= pct_zero ? PCT_NONE : PCT_FULL;
    end else if ((state == ST_DIV) && div_done) begin
      pct <= quot;
    end
    if (load_out) begin
      overcurrent_flag  <= oc_q;
      undervoltage_flag <= uv_q;
      energy_level      <= energy;
      peak_energy       <= peak;
      level_percent     <= pct;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !(out_valid && out_stall))
    else $error("result loaded over a held result");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_MUL))
    else $error("multiplier finished outside the multiply phase");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_percent <= PCT_FULL))
    else $error("percentage above full scale");

  a_peak_sample: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PEAK) && !kind_q && !neg_q |=> (peak >= energy))
    else $error("peak below energy after a gain");
`endif

endmodule

@@ tb/battery_energy_gauge_tb.sv @@
// self-checking testbench for the battery energy gauge: directed table, then random load phases
`timescale 1ns / 1ps

module battery_energy_gauge_tb import bgauge_pkg::*; ();

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_WAKE   = 1'b1;
  localparam int   PCT_SCALE   = 100;
  localparam int   RUN_LIMIT   = 1000000;
  localparam int   SETTLE_CYCLES = 60;
  localparam int   DIR_ROWS    = 26;
  localparam int   N_PHASES    = 8;

  typedef enum logic {ROW_REQ, ROW_REG} row_op_t;
  typedef enum logic [1:0] {MODE_MIXED, MODE_FILL, MODE_DRAIN} load_mode_t;

  typedef struct packed {
    logic                 kind;
    logic [ELAPSED_W-1:0] elapsed;
    logic [POWER_W-1:0]   power;
    logic [CUR_W-1:0]     current;
    logic [VOLT_W-1:0]    voltage;
  } sample_req_t;

  typedef struct packed {
    logic                oc;
    logic                uv;
    logic [ENERGY_W-1:0] energy;
    logic [ENERGY_W-1:0] peak;
    logic [PCT_W-1:0]    pct;
  } reading_t;

  typedef struct packed {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    sample_req_t           req;
    logic                  known;
    reading_t              res;
  } dir_row_t;

  localparam reading_t READ_EMPTY = '0;
  localparam reading_t READ_UNIT  = '{1'b0, 1'b0, 62'd1, 62'd1, PCT_FULL};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  kind = 1'b0;
  logic [ELAPSED_W-1:0]  elapsed_ms = '0;
  logic [POWER_W-1:0]    power_mw = '0;
  logic [CUR_W-1:0]      current_ma = '0;
  logic [VOLT_W-1:0]     voltage_mv = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  overcurrent_flag;
  logic                  undervoltage_flag;
  logic [ENERGY_W-1:0]   energy_level;
  logic [ENERGY_W-1:0]   peak_energy;
  logic [PCT_W-1:0]      level_percent;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  battery_energy_gauge u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .kind              (kind),
    .elapsed_ms        (elapsed_ms),
    .power_mw          (power_mw),
    .current_ma        (current_ma),
    .voltage_mv        (voltage_mv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .overcurrent_flag  (overcurrent_flag),
    .undervoltage_flag (undervoltage_flag),
    .energy_level      (energy_level),
    .peak_energy       (peak_energy),
    .level_percent     (level_percent),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // predictor copy of the settings and the energy store
  logic signed [CUR_W-1:0]   lim_oc = OC_LIMIT_RST;
  logic [VOLT_W-1:0]         lim_uv = UV_LIMIT_RST;
  logic signed [POWER_W-1:0] sleep_pw = SLEEP_POWER_RST;
  logic [63:0]               gauge_energy = '0;
  logic [63:0]               gauge_peak = '0;

  reading_t pending_readings [$];
  dir_row_t dir_tab [DIR_ROWS];
  logic     idle_on = 1'b1;
  int       rx_hold = 0;
  int       cycles = 0;
  int       n_req = 0;
  int       n_wake = 0;
  int       n_checked = 0;
  int       n_mismatch = 0;
  int       n_emptied = 0;
  int       n_saturated = 0;

  initial forever #4 clk = ~clk;

  function automatic reading_t advance_gauge(sample_req_t r);
    longint      delta;
    logic [63:0] mag;
    logic [63:0] sum;
    logic [71:0] scaled;
    reading_t    rd;
    rd = '0;
    if (r.kind == KIND_SAMPLE) begin
      delta = longint'($signed(r.power)) * longint'(r.elapsed);
      rd.oc = $signed(r.current) > lim_oc;
      rd.uv = r.voltage < lim_uv;
    end else begin
      delta = longint'(sleep_pw) * longint'(r.elapsed);
    end
    if (delta < 0) begin
      mag = 64'(-delta);
      gauge_energy = (mag >= gauge_energy) ? 64'd0 : gauge_energy - mag;
      if (gauge_energy == 0)
        n_emptied++;
    end else begin
      sum = gauge_energy + 64'(delta);
      if (sum > 64'(ENERGY_MAX)) begin
        sum = 64'(ENERGY_MAX);
        n_saturated++;
      end
      gauge_energy = sum;
    end
    // a zero product still counts as charging for the peak
    if (r.kind == KIND_SAMPLE && delta >= 0 && gauge_energy > gauge_peak)
      gauge_peak = gauge_energy;
    rd.energy = gauge_energy[ENERGY_W-1:0];
    rd.peak   = gauge_peak[ENERGY_W-1:0];
    if (gauge_peak == 0) begin
      rd.pct = PCT_NONE;
    end else if (gauge_energy >= gauge_peak) begin
      rd.pct = PCT_FULL;
    end else begin
      scaled = 72'(gauge_energy) * 72'(PCT_SCALE);
      rd.pct = PCT_W'(scaled / 72'(gauge_peak));
    end
    return rd;
  endfunction

  function automatic sample_req_t draw_req(load_mode_t mode);
    sample_req_t r;
    int          sel;
    int          mag;
    r.current = CUR_W'($urandom);
    r.voltage = VOLT_W'($urandom);
    sel = $urandom_range(0, 7);
    if (sel == 0)
      r.current = lim_oc;
    else if (sel == 1)
      r.current = CUR_W'(lim_oc + 1);
    sel = $urandom_range(0, 7);
    if (sel == 0)
      r.voltage = lim_uv;
    else if (sel == 1)
      r.voltage = VOLT_W'(lim_uv - 1);
    case (mode)
      MODE_FILL: begin
        r.kind    = ($urandom_range(0, 15) == 0) ? KIND_WAKE : KIND_SAMPLE;
        r.elapsed = '1;
        r.power   = 24'h7fffff;
      end
      MODE_DRAIN: begin
        r.kind    = ($urandom_range(0, 3) == 0) ? KIND_WAKE : KIND_SAMPLE;
        r.elapsed = $urandom;
        r.power   = POWER_W'(-int'($urandom_range(1, 8388608)));
      end
      default: begin
        r.kind = ($urandom_range(0, 7) == 0) ? KIND_WAKE : KIND_SAMPLE;
        sel = $urandom_range(0, 9);
        case (sel)
          0:       r.elapsed = '0;
          1:       r.elapsed = '1;
          2, 3:    r.elapsed = $urandom_range(0, 200);
          default: r.elapsed = $urandom;
        endcase
        sel = $urandom_range(0, 9);
        mag = $urandom_range(0, 8388607);
        case (sel)
          0:       r.power = 24'h7fffff;
          1:       r.power = 24'h800000;
          2:       r.power = '0;
          // slight charge bias so the peak keeps moving
          default: r.power = ($urandom_range(0, 4) < 2) ? POWER_W'(-mag) : POWER_W'(mag);
        endcase
      end
    endcase
    return r;
  endfunction

  task automatic send_req(input sample_req_t r, input logic known, input reading_t typed);
    int       gap;
    reading_t rd;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (cfg_valid)
      cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= r.kind;
    elapsed_ms <= r.elapsed;
    power_mw   <= r.power;
    current_ma <= r.current;
    voltage_mv <= r.voltage;
    do @(posedge clk); while (in_stall);
    rd = advance_gauge(r);
    n_req++;
    if (r.kind == KIND_WAKE)
      n_wake++;
    pending_readings.push_back(known ? typed : rd);
  endtask

  // settings only change once every reading has been taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OC_LIMIT:    lim_oc = data[CUR_W-1:0];
      CFG_UV_LIMIT:    lim_uv = data[VOLT_W-1:0];
      CFG_SLEEP_POWER: sleep_pw = data[POWER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic take_reading();
    reading_t want;
    if (pending_readings.size() == 0) begin
      $error("reading with no request pending: energy %0d peak %0d", energy_level, peak_energy);
      n_mismatch++;
    end else begin
      want = pending_readings.pop_front();
      n_checked++;
      if (overcurrent_flag !== want.oc) begin
        $error("overcurrent_flag: expected %0d, got %0d", want.oc, overcurrent_flag);
        n_mismatch++;
      end
      if (undervoltage_flag !== want.uv) begin
        $error("undervoltage_flag: expected %0d, got %0d", want.uv, undervoltage_flag);
        n_mismatch++;
      end
      if (energy_level !== want.energy) begin
        $error("energy_level: expected %0d, got %0d", want.energy, energy_level);
        n_mismatch++;
      end
      if (peak_energy !== want.peak) begin
        $error("peak_energy: expected %0d, got %0d", want.peak, peak_energy);
        n_mismatch++;
      end
      if (level_percent !== want.pct) begin
        $error("level_percent: expected %0d, got %0d", want.pct, level_percent);
        n_mismatch++;
      end
    end
  endtask

  // result side: after each reading hold stall for a drawn number of cycles with a reading waiting
  always @(posedge clk) begin : rx_side
    int draw;
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && !out_stall) begin
      take_reading();
      draw = idle_on ? $urandom_range(0, 4) : 0;
      rx_hold   <= draw;
      out_stall <= (draw != 0);
    end else if (out_valid && rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_stall <= (rx_hold > 1);
    end
  end

  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL battery_energy_gauge");
    $finish;
  end

  initial begin
    load_mode_t  mode;
    int          n_items;
    sample_req_t r;

    dir_tab = '{
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'h0000_0000, 24'h000000, 16'h0000, 16'h0000},
        1'b1, READ_EMPTY},
      // deepest discharge from empty clamps at zero; current at the limit does not flag
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'hffff_ffff, 24'h800000, 16'h7fff, 16'h0000},
        1'b1, READ_EMPTY},
      // wake-up ignores the sample fields
      '{ROW_REQ, '0, '0, '{KIND_WAKE, 32'hffff_ffff, 24'h7fffff, 16'h7fff, 16'hffff},
        1'b1, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'h0000_03e8, 24'h000000, 16'h8000, 16'hffff},
        1'b1, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'h0000_0001, 24'h000001, 16'h0000, 16'h0000},
        1'b1, READ_UNIT},
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'hffff_ffff, 24'h7fffff, 16'h1234, 16'h0000},
        1'b0, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'h0000_03e8, 24'hfffc18, 16'h0000, 16'h0000},
        1'b0, READ_EMPTY},
      '{ROW_REG, CFG_OC_LIMIT, 24'h008000, '0, 1'b0, READ_EMPTY},
      '{ROW_REG, CFG_UV_LIMIT, 24'h00ffff, '0, 1'b0, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'h0000_0064, 24'h000032, 16'h8000, 16'hfffe},
        1'b0, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'h0000_0064, 24'hffffce, 16'h8001, 16'hffff},
        1'b0, READ_EMPTY},
      '{ROW_REG, CFG_OC_LIMIT, 24'h000000, '0, 1'b0, READ_EMPTY},
      '{ROW_REG, CFG_UV_LIMIT, 24'h000001, '0, 1'b0, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'h0000_000a, 24'h000000, 16'h0001, 16'h0000},
        1'b0, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'h0000_000a, 24'h000000, 16'h0000, 16'h0001},
        1'b0, READ_EMPTY},
      '{ROW_REG, CFG_SLEEP_POWER, 24'h800000, '0, 1'b0, READ_EMPTY},
      // wake-up flags stay low even where a sample would flag both
      '{ROW_REQ, '0, '0, '{KIND_WAKE, 32'h0000_03e8, 24'h000000, 16'h7fff, 16'h0000},
        1'b0, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_WAKE, 32'hffff_ffff, 24'h000000, 16'h0000, 16'h0000},
        1'b0, READ_EMPTY},
      // positive sleep power charges without touching the peak
      '{ROW_REG, CFG_SLEEP_POWER, 24'h7fffff, '0, 1'b0, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_WAKE, 32'hffff_ffff, 24'h000000, 16'h0000, 16'h0000},
        1'b0, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_WAKE, 32'hffff_ffff, 24'h000000, 16'h0000, 16'h0000},
        1'b0, READ_EMPTY},
      '{ROW_REG, CFG_SLEEP_POWER, 24'h000000, '0, 1'b0, READ_EMPTY},
      '{ROW_REG, CFG_OC_LIMIT, 24'h007fff, '0, 1'b0, READ_EMPTY},
      '{ROW_REG, CFG_UV_LIMIT, 24'h000000, '0, 1'b0, READ_EMPTY},
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'h0000_0005, 24'hffffff, 16'h0000, 16'h0000},
        1'b0, READ_EMPTY},
      // zero product with negative power may still raise the peak
      '{ROW_REQ, '0, '0, '{KIND_SAMPLE, 32'h0000_0000, 24'h800000, 16'h0000, 16'h0000},
        1'b0, READ_EMPTY}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_REG)
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_data);
      else
        send_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].res);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        1, 4, 7: mode = MODE_DRAIN;
        6:       mode = MODE_FILL;
        default: mode = MODE_MIXED;
      endcase
      case (ph)
        0:       write_reg(CFG_OC_LIMIT, 24'h008000);
        1:       write_reg(CFG_OC_LIMIT, 24'h007fff);
        default: write_reg(CFG_OC_LIMIT, CFG_DATA_W'($urandom_range(0, 65535)));
      endcase
      case (ph)
        0:       write_reg(CFG_UV_LIMIT, 24'h00ffff);
        1:       write_reg(CFG_UV_LIMIT, 24'h000000);
        default: write_reg(CFG_UV_LIMIT, CFG_DATA_W'($urandom_range(0, 65535)));
      endcase
      case (ph)
        0:       write_reg(CFG_SLEEP_POWER, 24'h800000);
        1:       write_reg(CFG_SLEEP_POWER, 24'h000000);
        2:       write_reg(CFG_SLEEP_POWER, 24'hffffff);
        default: write_reg(CFG_SLEEP_POWER, CFG_DATA_W'(-int'($urandom_range(0, 8388608))));
      endcase
      // two phases run back to back with no gaps on either side
      idle_on = !(ph == 2 || ph == 5);
      n_items = (mode == MODE_FILL) ? 200 : 110;
      for (int k = 0; k < n_items; k++) begin
        r = draw_req(mode);
        send_req(r, 1'b0, READ_EMPTY);
      end
    end

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("gauge run: %0d requests (%0d wake-ups), %0d readings checked, %0d mismatches",
             n_req, n_wake, n_checked, n_mismatch);
    $display("energy emptied to zero %0d times, held at full scale %0d times, %0d cycles",
             n_emptied, n_saturated, cycles);
    if (n_mismatch == 0)
      $display("PASS battery_energy_gauge");
    else
      $display("FAIL battery_energy_gauge");
    $finish;
  end

endmodule

@@ battery_energy_gauge.f @@
rtl/bgauge_pkg.sv
rtl/bgauge_mult.sv
rtl/bgauge_div.sv
rtl/battery_energy_gauge.sv
tb/battery_energy_gauge_tb.sv
